// ===== rtl/lbm_bgk_collision_assert.svh =====
// ----------------------------------------------------------------------------
// LBM BGK collision assertion macros
// Shared concurrent assertion wrappers for the collision kernel.
// ----------------------------------------------------------------------------
`ifndef LBM_BGK_COLLISION_ASSERT_SVH
`define LBM_BGK_COLLISION_ASSERT_SVH

`ifndef ASSERT_OFF
`define LBC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define LBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LBC_ASSERT(lbl, clk, rst_n, prop, msg)
`define LBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/lbc_pkg.sv =====
// ----------------------------------------------------------------------------
// LBM BGK collision package
// Widths, constants, the request type and saturating helpers.
// ----------------------------------------------------------------------------
package lbc_pkg;

    localparam int VAL_W     = 32;
    localparam int FRAC_W    = 24;
    localparam int DIR_W     = 2;
    localparam int WGT_W     = 25;
    localparam int TAU_W     = 31;
    localparam int IN_DATA_W = 288;
    localparam int MUL_LAT   = 2;
    localparam int DIV_STEPS = VAL_W;
    localparam int DIV_LAT   = DIV_STEPS + 2;

    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic signed [DIR_W-1:0] t_dir;

    localparam t_val VMAX    = {1'b0, {(VAL_W-1){1'b1}}};
    localparam t_val VMIN    = {1'b1, {(VAL_W-1){1'b0}}};
    localparam t_val Q_ONE   = VAL_W'(1 << FRAC_W);
    localparam t_val Q_THREE = VAL_W'(3 * (1 << FRAC_W));
    localparam t_val Q_4P5   = VAL_W'(9 * (1 << FRAC_W) / 2);
    localparam t_val Q_1P5   = VAL_W'(3 * (1 << FRAC_W) / 2);

    localparam t_dir DIR_ZERO = 2'b00;
    localparam t_dir DIR_POS  = 2'b01;
    localparam t_dir DIR_NEG2 = 2'b10;
    localparam t_dir DIR_NEG  = 2'b11;

    typedef struct packed {
        t_val             pop_in;
        t_val             density;
        t_val             vel_x;
        t_val             vel_y;
        t_val             vel_z;
        t_val             force_x;
        t_val             force_y;
        t_val             force_z;
        t_dir             dir_x;
        t_dir             dir_y;
        t_dir             dir_z;
        logic [WGT_W-1:0] lattice_weight;
        logic             bad_density;
    } t_item;

    function automatic t_val sat_add(t_val a, t_val b);
        logic signed [VAL_W:0] s;
        s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        if (s[VAL_W] != s[VAL_W-1]) return s[VAL_W] ? VMIN : VMAX;
        return t_val'(s[VAL_W-1:0]);
    endfunction

    function automatic t_val sat_sub(t_val a, t_val b);
        logic signed [VAL_W:0] s;
        s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
        if (s[VAL_W] != s[VAL_W-1]) return s[VAL_W] ? VMIN : VMAX;
        return t_val'(s[VAL_W-1:0]);
    endfunction

    function automatic t_val sat_neg(t_val a);
        return (a == VMIN) ? VMAX : -a;
    endfunction

    function automatic t_val dir_term(t_dir d, t_val x);
        t_val r;
        case (d)
            DIR_POS:  r = x;
            DIR_NEG:  r = sat_neg(x);
            DIR_NEG2: r = sat_add(sat_neg(x), sat_neg(x));
            default:  r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/lbc_mul.sv =====
// ----------------------------------------------------------------------------
// LBM BGK collision fixed-point multiplier
// Two-stage Q8.24 product, rounded half away from zero and saturated.
// ----------------------------------------------------------------------------
module lbc_mul (
    input  logic          i_clk,
    input  logic          i_en,
    input  lbc_pkg::t_val i_a,
    input  lbc_pkg::t_val i_b,
    output lbc_pkg::t_val o_p
);
    import lbc_pkg::*;

    localparam int PW = 2 * VAL_W;
    localparam int MW = PW + 1 - FRAC_W;

    logic [VAL_W-1:0] mag_a;
    logic [VAL_W-1:0] mag_b;
    logic             r_neg;
    logic [PW-1:0]    r_prod;
    logic [PW:0]      rnd;
    logic [MW-1:0]    mag;
    logic [MW-1:0]    lim;
    logic [MW-1:0]    sel;
    t_val             r_p;

    assign mag_a = i_a[VAL_W-1] ? VAL_W'(-i_a) : VAL_W'(i_a);
    assign mag_b = i_b[VAL_W-1] ? VAL_W'(-i_b) : VAL_W'(i_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg  <= i_a[VAL_W-1] ^ i_b[VAL_W-1];
            r_prod <= PW'(mag_a) * PW'(mag_b);
        end
    end

    always_comb begin
        rnd = {1'b0, r_prod} + ((PW+1)'(1) << (FRAC_W - 1));
        mag = rnd[PW:FRAC_W];
        lim = r_neg ? (MW'(1) << (VAL_W - 1)) : ((MW'(1) << (VAL_W - 1)) - MW'(1));
        sel = (mag > lim) ? lim : mag;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= r_neg ? -t_val'(sel[VAL_W-1:0]) : t_val'(sel[VAL_W-1:0]);
        end
    end

    assign o_p = r_p;

endmodule

// ===== rtl/lbc_div.sv =====
// ----------------------------------------------------------------------------
// LBM BGK collision fixed-point divider
// Pipelined restoring divider, one quotient bit per stage, for (a << 24) / b.
// ----------------------------------------------------------------------------
module lbc_div (
    input  logic          i_clk,
    input  logic          i_en,
    input  lbc_pkg::t_val i_num,
    input  lbc_pkg::t_val i_den,
    output lbc_pkg::t_val o_q
);
    import lbc_pkg::*;

    localparam int SH = VAL_W - FRAC_W;

    logic [VAL_W-1:0]    m_abs;
    logic [VAL_W-1:0]    d_abs;
    logic                den_zero;

    logic [VAL_W-1:0]    r_rem [DIV_STEPS+1];
    logic [VAL_W-1:0]    r_q   [DIV_STEPS+1];
    logic [VAL_W-1:0]    r_nl  [DIV_STEPS+1];
    logic [VAL_W-1:0]    r_d   [DIV_STEPS+1];
    logic                r_neg [DIV_STEPS+1];
    logic                r_ovf [DIV_STEPS+1];

    logic [VAL_W-1:0]    n_rem [DIV_STEPS];
    logic [VAL_W-1:0]    n_q   [DIV_STEPS];

    logic [VAL_W:0]      q_rnd;
    logic [VAL_W:0]      lim;
    logic [VAL_W:0]      sel;
    logic                rnd_up;
    t_val                r_out;

    assign m_abs    = i_num[VAL_W-1] ? VAL_W'(-i_num) : VAL_W'(i_num);
    assign den_zero = (i_den == '0);
    assign d_abs    = den_zero ? VAL_W'(1)
                    : (i_den[VAL_W-1] ? VAL_W'(-i_den) : VAL_W'(i_den));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= VAL_W'(m_abs >> SH);
            r_q[0]   <= '0;
            r_nl[0]  <= m_abs << FRAC_W;
            r_d[0]   <= d_abs;
            r_neg[0] <= i_num[VAL_W-1] ^ (i_den[VAL_W-1] & ~den_zero);
            r_ovf[0] <= den_zero ? (i_num != '0)
                      : ({{SH{1'b0}}, m_abs} >= {d_abs, {SH{1'b0}}});
        end
    end

    always_comb begin
        for (int k = 0; k < DIV_STEPS; k++) begin
            logic [VAL_W:0] t;
            logic           ge;
            t        = {r_rem[k], r_nl[k][VAL_W-1]};
            ge       = (t >= {1'b0, r_d[k]});
            n_rem[k] = ge ? VAL_W'(t - {1'b0, r_d[k]}) : t[VAL_W-1:0];
            n_q[k]   = {r_q[k][VAL_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_rem[k+1] <= n_rem[k];
                r_q[k+1]   <= n_q[k];
                r_nl[k+1]  <= r_nl[k] << 1;
                r_d[k+1]   <= r_d[k];
                r_neg[k+1] <= r_neg[k];
                r_ovf[k+1] <= r_ovf[k];
            end
        end
    end

    always_comb begin
        rnd_up = ({r_rem[DIV_STEPS], 1'b0} >= {1'b0, r_d[DIV_STEPS]});
        q_rnd  = {1'b0, r_q[DIV_STEPS]} + (VAL_W+1)'(rnd_up);
        lim    = r_neg[DIV_STEPS] ? ((VAL_W+1)'(1) << (VAL_W - 1))
               : (((VAL_W+1)'(1) << (VAL_W - 1)) - (VAL_W+1)'(1));
        sel    = (r_ovf[DIV_STEPS] || (q_rnd > lim)) ? lim : q_rnd;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= r_neg[DIV_STEPS] ? -t_val'(sel[VAL_W-1:0]) : t_val'(sel[VAL_W-1:0]);
        end
    end

    assign o_q = r_out;

endmodule

// ===== rtl/lbc_front.sv =====
// ----------------------------------------------------------------------------
// LBM BGK collision front end
// Accepts input requests, unpacks the fields and flags bad densities.
// ----------------------------------------------------------------------------
module lbc_front (
    input  logic                          i_tvalid,
    output logic                          o_tready,
    input  logic [lbc_pkg::IN_DATA_W-1:0] i_tdata,
    input  logic                          i_full,
    output logic                          o_push,
    output lbc_pkg::t_item                o_item
);
    import lbc_pkg::*;

    t_item item;

    always_comb begin
        item.pop_in         = t_val'(i_tdata[0*VAL_W +: VAL_W]);
        item.density        = t_val'(i_tdata[1*VAL_W +: VAL_W]);
        item.vel_x          = t_val'(i_tdata[2*VAL_W +: VAL_W]);
        item.vel_y          = t_val'(i_tdata[3*VAL_W +: VAL_W]);
        item.vel_z          = t_val'(i_tdata[4*VAL_W +: VAL_W]);
        item.force_x        = t_val'(i_tdata[5*VAL_W +: VAL_W]);
        item.force_y        = t_val'(i_tdata[6*VAL_W +: VAL_W]);
        item.force_z        = t_val'(i_tdata[7*VAL_W +: VAL_W]);
        item.dir_x          = t_dir'(i_tdata[8*VAL_W +: DIR_W]);
        item.dir_y          = t_dir'(i_tdata[8*VAL_W + DIR_W +: DIR_W]);
        item.dir_z          = t_dir'(i_tdata[8*VAL_W + 2*DIR_W +: DIR_W]);
        item.lattice_weight = i_tdata[8*VAL_W + 3*DIR_W +: WGT_W];
        item.bad_density    = (item.density <= t_val'(0));
    end

    assign o_tready = ~i_full;
    assign o_push   = i_tvalid & ~i_full;
    assign o_item   = item;

endmodule

// ===== rtl/lbc_queue.sv =====
// ----------------------------------------------------------------------------
// LBM BGK collision request queue
// Two-entry queue between the front end and the datapath.
// ----------------------------------------------------------------------------
`include "lbm_bgk_collision_assert.svh"

module lbc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lbc_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_vld,
    output lbc_pkg::t_item o_head
);
    import lbc_pkg::*;

    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign push = i_push && (r_cnt != 2'd2);
    assign pop  = i_pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)  r_rd_ptr <= ~r_rd_ptr;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    assign o_full = (r_cnt == 2'd2);
    assign o_vld  = (r_cnt != 2'd0);
    assign o_head = r_mem[r_rd_ptr];

    `LBC_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt <= 2'd2, "queue count out of range")
    `LBC_ASSERT_NEXT(a_cnt_up, i_clk, i_rst_n, push && !pop, r_cnt == $past(r_cnt) + 2'd1, "queue count did not rise")
    `LBC_ASSERT_NEXT(a_cnt_dn, i_clk, i_rst_n, pop && !push, r_cnt == $past(r_cnt) - 2'd1, "queue count did not fall")

endmodule

// ===== rtl/lbc_back.sv =====
// ----------------------------------------------------------------------------
// LBM BGK collision datapath
// Velocity shift, equilibrium and relaxation pipeline with output register.
// ----------------------------------------------------------------------------
module lbc_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [lbc_pkg::TAU_W-1:0] i_tau,
    input  logic                      i_head_vld,
    input  lbc_pkg::t_item            i_head,
    output logic                      o_pop,
    output logic                      o_tvalid,
    input  logic                      i_tready,
    output lbc_pkg::t_val             o_pop_out,
    output logic                      o_bad
);
    import lbc_pkg::*;

    localparam int T_PF   = MUL_LAT;
    localparam int T_Q    = T_PF + DIV_LAT;
    localparam int T_U    = T_Q + 1;
    localparam int T_EV   = T_U + 1;
    localparam int T_M2   = T_EV + 2 * MUL_LAT;
    localparam int T_POLY = T_M2 + 1;
    localparam int T_FEQ  = T_POLY + MUL_LAT;
    localparam int T_DIFF = T_FEQ + 1;
    localparam int T_QT   = T_DIFF + DIV_LAT;

    localparam int RHO_DLY = T_PF;
    localparam int VEL_DLY = T_Q;
    localparam int DIR_DLY = T_U;
    localparam int RW_DLY  = T_POLY - T_PF;
    localparam int M3_DLY  = MUL_LAT;
    localparam int F_DLY   = T_QT;

    logic en;
    t_val tau_v;

    t_item r_s0;
    logic  r_v0;

    t_val             r_rho_d [RHO_DLY];
    t_val             r_vx_d  [VEL_DLY];
    t_val             r_vy_d  [VEL_DLY];
    t_val             r_vz_d  [VEL_DLY];
    logic [3*DIR_W-1:0] r_dir_d [DIR_DLY];
    t_val             r_rw_d  [RW_DLY];
    t_val             r_m3_d  [M3_DLY];
    t_val             r_f_d   [F_DLY];
    logic             r_bad_d [F_DLY];
    logic             r_vld_d [F_DLY];

    t_val pfx, pfy, pfz, qx, qy, qz, rw;
    t_val r_ux, r_uy, r_uz, r_ev, r_uu, r_poly, r_diff;
    t_val sxx, syy, szz, m3, mee, m45, m15, feq, qt;
    t_dir ex, ey, ez;

    logic r_out_vld;
    t_val r_out_pop;
    logic r_out_bad;

    assign en    = ~r_out_vld | i_tready;
    assign o_pop = en;
    assign tau_v = t_val'({1'b0, i_tau});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0 <= i_head;
        end
    end

    lbc_mul u_mfx (.i_clk, .i_en(en), .i_a(tau_v), .i_b(r_s0.force_x), .o_p(pfx));
    lbc_mul u_mfy (.i_clk, .i_en(en), .i_a(tau_v), .i_b(r_s0.force_y), .o_p(pfy));
    lbc_mul u_mfz (.i_clk, .i_en(en), .i_a(tau_v), .i_b(r_s0.force_z), .o_p(pfz));
    lbc_mul u_mrw (.i_clk, .i_en(en), .i_a(r_s0.density),
                   .i_b(t_val'({{(VAL_W-WGT_W){1'b0}}, r_s0.lattice_weight})), .o_p(rw));

    lbc_div u_dx (.i_clk, .i_en(en), .i_num(pfx), .i_den(r_rho_d[RHO_DLY-1]), .o_q(qx));
    lbc_div u_dy (.i_clk, .i_en(en), .i_num(pfy), .i_den(r_rho_d[RHO_DLY-1]), .o_q(qy));
    lbc_div u_dz (.i_clk, .i_en(en), .i_num(pfz), .i_den(r_rho_d[RHO_DLY-1]), .o_q(qz));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rho_d[0] <= r_s0.density;
            for (int k = 1; k < RHO_DLY; k++) r_rho_d[k] <= r_rho_d[k-1];
            r_vx_d[0] <= r_s0.vel_x;
            r_vy_d[0] <= r_s0.vel_y;
            r_vz_d[0] <= r_s0.vel_z;
            for (int k = 1; k < VEL_DLY; k++) begin
                r_vx_d[k] <= r_vx_d[k-1];
                r_vy_d[k] <= r_vy_d[k-1];
                r_vz_d[k] <= r_vz_d[k-1];
            end
            r_dir_d[0] <= {r_s0.dir_x, r_s0.dir_y, r_s0.dir_z};
            for (int k = 1; k < DIR_DLY; k++) r_dir_d[k] <= r_dir_d[k-1];
            r_rw_d[0] <= rw;
            for (int k = 1; k < RW_DLY; k++) r_rw_d[k] <= r_rw_d[k-1];
            r_m3_d[0] <= m3;
            for (int k = 1; k < M3_DLY; k++) r_m3_d[k] <= r_m3_d[k-1];
            r_f_d[0]   <= r_s0.pop_in;
            r_bad_d[0] <= r_s0.bad_density;
            for (int k = 1; k < F_DLY; k++) begin
                r_f_d[k]   <= r_f_d[k-1];
                r_bad_d[k] <= r_bad_d[k-1];
            end
        end
    end

    assign ex = t_dir'(r_dir_d[DIR_DLY-1][3*DIR_W-1 -: DIR_W]);
    assign ey = t_dir'(r_dir_d[DIR_DLY-1][2*DIR_W-1 -: DIR_W]);
    assign ez = t_dir'(r_dir_d[DIR_DLY-1][DIR_W-1 -: DIR_W]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ux   <= sat_add(r_vx_d[VEL_DLY-1], qx);
            r_uy   <= sat_add(r_vy_d[VEL_DLY-1], qy);
            r_uz   <= sat_add(r_vz_d[VEL_DLY-1], qz);
            r_ev   <= sat_add(sat_add(dir_term(ex, r_ux), dir_term(ey, r_uy)),
                              dir_term(ez, r_uz));
            r_uu   <= sat_add(sat_add(sxx, syy), szz);
            r_poly <= sat_sub(sat_add(sat_add(Q_ONE, r_m3_d[M3_DLY-1]), m45), m15);
            r_diff <= sat_sub(r_f_d[T_FEQ-1], feq);
        end
    end

    lbc_mul u_mxx (.i_clk, .i_en(en), .i_a(r_ux), .i_b(r_ux), .o_p(sxx));
    lbc_mul u_myy (.i_clk, .i_en(en), .i_a(r_uy), .i_b(r_uy), .o_p(syy));
    lbc_mul u_mzz (.i_clk, .i_en(en), .i_a(r_uz), .i_b(r_uz), .o_p(szz));
    lbc_mul u_m3  (.i_clk, .i_en(en), .i_a(Q_THREE), .i_b(r_ev), .o_p(m3));
    lbc_mul u_mee (.i_clk, .i_en(en), .i_a(r_ev), .i_b(r_ev), .o_p(mee));
    lbc_mul u_m45 (.i_clk, .i_en(en), .i_a(Q_4P5), .i_b(mee), .o_p(m45));
    lbc_mul u_m15 (.i_clk, .i_en(en), .i_a(Q_1P5), .i_b(r_uu), .o_p(m15));
    lbc_mul u_feq (.i_clk, .i_en(en), .i_a(r_poly), .i_b(r_rw_d[RW_DLY-1]), .o_p(feq));
    lbc_div u_dt  (.i_clk, .i_en(en), .i_num(r_diff), .i_den(tau_v), .o_q(qt));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0      <= 1'b0;
            r_out_vld <= 1'b0;
            for (int k = 0; k < F_DLY; k++) r_vld_d[k] <= 1'b0;
        end else if (en) begin
            r_v0       <= i_head_vld;
            r_vld_d[0] <= r_v0;
            for (int k = 1; k < F_DLY; k++) r_vld_d[k] <= r_vld_d[k-1];
            r_out_vld  <= r_vld_d[F_DLY-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_bad <= r_bad_d[F_DLY-1];
            r_out_pop <= r_bad_d[F_DLY-1] ? r_f_d[F_DLY-1] : sat_sub(r_f_d[F_DLY-1], qt);
        end
    end

    assign o_tvalid  = r_out_vld;
    assign o_pop_out = r_out_pop;
    assign o_bad     = r_out_bad;

endmodule

// ===== rtl/lbm_bgk_collision.sv =====
// ----------------------------------------------------------------------------
// LBM BGK collision kernel
// One population per request is relaxed toward its forced second-order
// equilibrium in signed Q8.24 with saturation. The kernel accepts one request
// per clock while the output is not stalled and presents results in order;
// its depth is mostly the two chained 32-stage dividers, one for the force
// shift by density and one for the division by the relaxation time. A short
// queue sits between the input side and the datapath, and the whole datapath
// holds while the output request waits. Write the relaxation time only while
// no request is in flight; it resets to 1.0.
// ----------------------------------------------------------------------------
module lbm_bgk_collision (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // pop_in, density, vel_x, vel_y, vel_z, force_x, force_y, force_z,
    // dir_x, dir_y, dir_z, lattice_weight, one pad bit
    input  logic [lbc_pkg::IN_DATA_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // pop_out
    output logic [lbc_pkg::VAL_W-1:0]     m_axis_tdata,
    // bad_density
    output logic [0:0]                    m_axis_tuser,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lbc_pkg::TAU_W-1:0]     i_cfg_data
);
    import lbc_pkg::*;

    logic [TAU_W-1:0] r_relax_time;
    logic             q_full;
    logic             q_push;
    logic             q_vld;
    logic             q_pop;
    t_item            f_item;
    t_item            q_head;
    t_val             pop_out;
    logic             bad;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relax_time <= TAU_W'(Q_ONE);
        end else if (i_cfg_valid) begin
            r_relax_time <= i_cfg_data;
        end
    end

    lbc_front u_front (
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_full   (q_full),
        .o_push   (q_push),
        .o_item   (f_item)
    );

    lbc_queue u_queue (
        .i_clk,
        .i_rst_n,
        .i_push (q_push),
        .i_item (f_item),
        .i_pop  (q_pop),
        .o_full (q_full),
        .o_vld  (q_vld),
        .o_head (q_head)
    );

    lbc_back u_back (
        .i_clk,
        .i_rst_n,
        .i_tau      (r_relax_time),
        .i_head_vld (q_vld),
        .i_head     (q_head),
        .o_pop      (q_pop),
        .o_tvalid   (m_axis_tvalid),
        .i_tready   (m_axis_tready),
        .o_pop_out  (pop_out),
        .o_bad      (bad)
    );

    assign m_axis_tdata = VAL_W'(pop_out);
    assign m_axis_tuser = bad;

endmodule
